// File: hw/rtl/bdcd_pkg.sv
// Package for the button double-click detector: sizes, register map and shared types.
package bdcd_pkg;

  localparam int unsigned BUTTONS      = 32;
  localparam int unsigned LEVELS_W     = 32;
  localparam int unsigned NOW_W        = 31;
  localparam int unsigned WINDOW_W     = 16;
  localparam int unsigned COUNT_W      = 6;
  localparam int unsigned DEADLINE_W   = 32;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 3;

  // Register index, taken from paddr[2] (registers sit at byte addresses 0 and 4).
  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_COUNT  = 1'b1
  } reg_idx_e;

  // Effective configuration as seen by the datapath.
  typedef struct packed {
    logic [WINDOW_W-1:0] window;  // zero already mapped to one
    logic [COUNT_W-1:0]  active;  // clamped to BUTTONS
  } cfg_t;

  // Per-button control and data from the compute stage.
  typedef struct packed {
    logic                fire;    // transaction is leaving the input register
    logic                active;  // button index below the active count
    logic                level;
    logic [NOW_W-1:0]    now;
    logic [WINDOW_W-1:0] window;
  } cell_in_t;

  typedef struct packed {
    logic held;
    logic dbl;
  } cell_out_t;

endpackage

// File: hw/rtl/bdcd_cfg.sv
// APB register block holding the click window and the active button count.
module bdcd_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bdcd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bdcd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bdcd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output bdcd_pkg::cfg_t                      cfg_o
);
  import bdcd_pkg::*;

  logic [WINDOW_W-1:0] window_q, window_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  reg_idx_e            idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    window_d = window_q;
    count_d  = count_q;
    prdata   = '0;
    unique case (idx)
      REG_WINDOW: begin
        prdata = {{(APB_DATA_W-WINDOW_W){1'b0}}, window_q};
        if (wr_en) window_d = pwdata[WINDOW_W-1:0];
      end
      REG_COUNT: begin
        prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, count_q};
        if (wr_en) count_d = pwdata[COUNT_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_W'(1);
      count_q  <= COUNT_W'(BUTTONS);
    end else begin
      window_q <= window_d;
      count_q  <= count_d;
    end
  end

  // Zero window behaves as one tick; counts past the button total clamp.
  assign cfg_o.window = (window_q == '0) ? WINDOW_W'(1) : window_q;
  assign cfg_o.active = (count_q > COUNT_W'(BUTTONS)) ? COUNT_W'(BUTTONS) : count_q;

endmodule

// File: hw/rtl/bdcd_cell.sv
// One button: press latch, click counter and deadline, with the double-click decision.
module bdcd_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bdcd_pkg::cell_in_t   cell_i,
  output bdcd_pkg::cell_out_t  cell_o
);
  import bdcd_pkg::*;

  typedef enum logic [1:0] {
    CNT_IDLE   = 2'd0,
    CNT_FIRST  = 2'd1,
    CNT_DOUBLE = 2'd2
  } cnt_e;

  logic                  latch_q, latch_d;
  cnt_e                  cnt_q, cnt_d;
  logic [DEADLINE_W-1:0] deadline_q, deadline_d;
  logic [DEADLINE_W-1:0] now_ext;
  logic                  expired;
  logic                  dbl;

  assign now_ext = {{(DEADLINE_W-NOW_W){1'b0}}, cell_i.now};
  assign expired = (cnt_q == CNT_IDLE) || (now_ext >= deadline_q);

  always_comb begin
    latch_d    = latch_q;
    cnt_d      = cnt_q;
    deadline_d = deadline_q;
    dbl        = 1'b0;
    if (cell_i.level) begin
      latch_d = 1'b1;
      if (!latch_q) begin
        if (expired) begin
          deadline_d = now_ext + {{(DEADLINE_W-WINDOW_W){1'b0}}, cell_i.window};
          cnt_d      = CNT_FIRST;
        end else begin
          dbl        = 1'b1;
          deadline_d = '0;
          cnt_d      = CNT_DOUBLE;
        end
      end else if (cnt_q == CNT_DOUBLE) begin
        cnt_d = CNT_FIRST;
      end
    end else begin
      if (cnt_q == CNT_DOUBLE) cnt_d = CNT_IDLE;
      latch_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= 1'b0;
      cnt_q   <= CNT_IDLE;
    end else if (cell_i.fire && cell_i.active) begin
      latch_q <= latch_d;
      cnt_q   <= cnt_d;
    end
  end

  // Deadline only matters once a first click is pending.
  always_ff @(posedge clk_i) begin
    if (cell_i.fire && cell_i.active) deadline_q <= deadline_d;
  end

  assign cell_o.held = cell_i.active && cell_i.level;
  assign cell_o.dbl  = cell_i.active && dbl;

endmodule

// File: hw/rtl/button_double_click_detector_core.sv
// Top level of the button double-click detector: poll pipeline, button cells, APB registers.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid_i / in_stall_o   | button_levels_i, now_i
//  out     | output    | out_valid_o / out_stall_i | held_bits_o, double_click_bits_o
//  cfg     | input     | APB psel/penable/pready   | click_window (0x0), button_count (0x4)
//
// A poll transaction lands in the input register; when it moves on, the cells update
// their state and the result register loads together, one poll per cycle while out_stall_i is low.
// Between the registers sit the per-button deadline add and compare and the click decision.
// Reset clears latches and click counts; registers return to window 1 and count 32.
// A stalled result holds; the input register still takes one more poll behind it,
// then in_stall_o rises until the result is taken.
module button_double_click_detector_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // poll input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [bdcd_pkg::LEVELS_W-1:0]        button_levels_i,
  input  logic [bdcd_pkg::NOW_W-1:0]           now_i,
  // result output
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [bdcd_pkg::LEVELS_W-1:0]        held_bits_o,
  output logic [bdcd_pkg::LEVELS_W-1:0]        double_click_bits_o,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bdcd_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [bdcd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [bdcd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import bdcd_pkg::*;

  cfg_t                cfg;

  // input register
  logic                in_valid_q, in_valid_d;
  logic [LEVELS_W-1:0] levels_q;
  logic [NOW_W-1:0]    now_q;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [LEVELS_W-1:0] held_q, dbl_q;

  logic                in_accept;
  logic                out_load;
  logic [LEVELS_W-1:0] active_mask;
  logic [LEVELS_W-1:0] held_d, dbl_d;

  bdcd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Compute stage fires when the input register holds a poll and the result register is empty or being drained.
  assign out_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept)     in_valid_d = 1'b1;
    else if (out_load) in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (out_load)          out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      levels_q <= button_levels_i;
      now_q    <= now_i;
    end
    if (out_load) begin
      held_q <= held_d;
      dbl_q  <= dbl_d;
    end
  end

  // Buttons past the configured count stay frozen and read as zero.
  always_comb begin
    active_mask = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      active_mask[i] = (COUNT_W'(i) < cfg.active);
    end
  end

  for (genvar g = 0; g < LEVELS_W; g++) begin : g_btn
    if (g < BUTTONS) begin : g_cell
      cell_in_t  c_in;
      cell_out_t c_out;

      assign c_in.fire   = out_load;
      assign c_in.active = active_mask[g];
      assign c_in.level  = levels_q[g];
      assign c_in.now    = now_q;
      assign c_in.window = cfg.window;

      bdcd_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .cell_i (c_in),
        .cell_o (c_out)
      );

      assign held_d[g] = c_out.held;
      assign dbl_d[g]  = c_out.dbl;
    end else begin : g_none
      assign held_d[g] = 1'b0;
      assign dbl_d[g]  = 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign held_bits_o         = held_q;
  assign double_click_bits_o = dbl_q;

  // A double click is only reported on a button that is down.
  a_dbl_implies_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((double_click_bits_o & ~held_bits_o) == '0))
    else $error("double click on a released button");

  // Inactive buttons never show up in a result.
  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (((held_bits_o | double_click_bits_o) & ~active_mask) == '0))
    else $error("inactive button reported");

  // A poll in the input register with a free result slot becomes a result next cycle.
  a_poll_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && !in_valid_q) || (out_valid_o && $past(in_accept)))
    else $error("poll lost between input and result register");

  // Input side only stalls when a poll is waiting behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("spurious input stall");

endmodule
